// ----- sv/fld_pkg.sv -----
// Shared types and constants for the fixed-length frame deframer.
`timescale 1ns / 1ps

package fld_pkg;

	typedef logic [7:0] byte_t;

	localparam int    CFG_W      = 7;
	localparam byte_t START_MARK = 8'h26;	// '&'
	localparam byte_t END_MARK   = 8'h0A;	// '\n'
	localparam logic [CFG_W-1:0] LEN_RESET = 7'd11;

	// Window cell control: advance the row, and whether this cell is the entry point.
	typedef struct packed {
		logic step;
		logic entry;
	} win_ctl_t;

	// Drain cell control: capture a frame byte, or move toward the head.
	typedef struct packed {
		logic load;
		logic pop;
	} drain_ctl_t;

endpackage

// ----- sv/fld_win_cell.sv -----
// One window cell: a history byte and a length-aligned byte.
`timescale 1ns / 1ps

module fld_win_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  fld_pkg::win_ctl_t ctl,
	input  fld_pkg::byte_t   feed_byte,
	input  fld_pkg::byte_t   w_prev,
	input  fld_pkg::byte_t   c_next,
	output fld_pkg::byte_t   w_q,
	output fld_pkg::byte_t   c_q
);
	import fld_pkg::*;

	// history row moves away from the input; aligned row moves toward cell 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= '0;
			c_q <= '0;
		end else if (ctl.step) begin
			w_q <= w_prev;
			c_q <= ctl.entry ? feed_byte : c_next;
		end
	end

endmodule

// ----- sv/fld_drain_cell.sv -----
// One drain cell: holds a payload byte waiting to go out.
`timescale 1ns / 1ps

module fld_drain_cell (
	input  logic               clk,
	input  fld_pkg::drain_ctl_t ctl,
	input  fld_pkg::byte_t     load_byte,
	input  fld_pkg::byte_t     next_byte,
	output fld_pkg::byte_t     d_q
);
	import fld_pkg::*;

	// load wins over pop: a new frame is captured only when the row is empty
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			d_q <= load_byte;
		end else if (ctl.pop) begin
			d_q <= next_byte;
		end
	end

endmodule

// ----- sv/fixed_length_frame_deframer.sv -----
// Top level: start/end delimited fixed-length frame deframer.
`timescale 1ns / 1ps
//
// channel  direction  handshake               payload
// -------  ---------  ----------------------  ---------------------------
// input    in         in_valid / in_stall     rx_byte
// output   out        out_valid / out_stall   payload_byte, frame_last
// config   in         cfg_valid / cfg_ready   cfg_data (payload_length)
//
// One received byte is taken per cycle while in_stall is low; a frame's payload
// leaves the drain row one byte per cycle while out_stall is low, starting the
// cycle after its end marker is taken. After a config write the aligned row is
// rebuilt by rotating the history row once, with in_stall high and cfg_ready low.
// in_stall also rises while no suppression counts, a start marker sits at the check
// position and the drain row still holds bytes, so output back-pressure reaches the
// input only then. Reset (arst_n low) clears the history and aligned rows to zero
// bytes, the suppress count and the drain count, and sets payload_length to 11.
//
// Structure: a row of window cells. Each holds one history byte (newest at cell 0)
// and one aligned byte; the aligned row takes new bytes in at cell len, so cell 0
// always holds the byte that would be the start marker and cells 1..len hold the
// payload in order. A frame is copied in parallel into a row of drain cells that
// shift toward the output at cell 0.

module fixed_length_frame_deframer #(
	parameter int MAX_PAYLOAD = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  fld_pkg::byte_t            rx_byte,
	output logic                      out_valid,
	input  logic                      out_stall,
	output fld_pkg::byte_t            payload_byte,
	output logic                      frame_last,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [fld_pkg::CFG_W-1:0] cfg_data
);
	import fld_pkg::*;

	localparam int CELLS = MAX_PAYLOAD + 1;			// history needed: up to MAX_PAYLOAD+1 bytes
	localparam int LW    = $clog2(MAX_PAYLOAD + 1);	// effective length / drain count
	localparam int SW    = $clog2(MAX_PAYLOAD + 2);	// suppress count holds len+1
	localparam int RW    = $clog2(CELLS + 1);		// realign counter

	logic [CFG_W-1:0] cfg_q;
	logic [LW-1:0]    len_eff;
	logic [SW-1:0]    supp_q;
	logic [LW-1:0]    cnt_q;
	logic             busy_q;
	logic [RW-1:0]    rcnt_q;

	logic             in_acc;
	logic             cfg_acc;
	logic             step;
	logic             pop;
	logic             hit;
	logic             frame_load;
	logic             start_at_check;
	byte_t            feed_byte;

	byte_t            w_row [CELLS];
	byte_t            c_row [CELLS];
	byte_t            d_row [MAX_PAYLOAD];
	logic [CELLS-1:0] entry_oh;

	// effective length: zero acts as one, saturate at MAX_PAYLOAD
	always_comb begin
		if (cfg_q == '0) begin
			len_eff = LW'(1);
		end else if (cfg_q > CFG_W'(MAX_PAYLOAD)) begin
			len_eff = LW'(MAX_PAYLOAD);
		end else begin
			len_eff = cfg_q[LW-1:0];
		end
	end

	assign cfg_ready = !busy_q;
	assign cfg_acc   = cfg_valid && cfg_ready;

	assign start_at_check = (c_row[0] == START_MARK);
	// stall while realigning, or when a frame could close now and the drain row is not free
	assign in_stall   = busy_q || ((supp_q == '0) && start_at_check && (cnt_q != '0));
	assign in_acc     = in_valid && !in_stall;
	assign hit        = (supp_q == '0) && start_at_check && (rx_byte == END_MARK);
	assign frame_load = in_acc && hit;

	// during realign the oldest history byte wraps around to the front
	assign feed_byte = busy_q ? w_row[CELLS-1] : rx_byte;
	assign step      = busy_q || in_acc;

	assign out_valid    = (cnt_q != '0);
	assign payload_byte = d_row[0];
	assign frame_last   = (cnt_q == LW'(1));
	assign pop          = out_valid && !out_stall;

	// window row
	for (genvar i = 0; i < CELLS; i++) begin : g_win
		win_ctl_t wctl;
		byte_t    w_prev;
		byte_t    c_next;

		assign entry_oh[i] = (len_eff == LW'(i));
		assign wctl        = '{step: step, entry: entry_oh[i]};

		if (i == 0) begin : g_head
			assign w_prev = feed_byte;
		end else begin : g_body
			assign w_prev = w_row[i-1];
		end

		if (i == CELLS - 1) begin : g_tail
			assign c_next = feed_byte;
		end else begin : g_mid
			assign c_next = c_row[i+1];
		end

		fld_win_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (wctl),
			.feed_byte (feed_byte),
			.w_prev    (w_prev),
			.c_next    (c_next),
			.w_q       (w_row[i]),
			.c_q       (c_row[i])
		);
	end

	// drain row: cell j takes aligned byte j+1 (oldest payload byte lands at the head)
	for (genvar j = 0; j < MAX_PAYLOAD; j++) begin : g_drain
		drain_ctl_t dctl;
		byte_t      next_byte;

		assign dctl = '{load: frame_load, pop: pop};

		if (j == MAX_PAYLOAD - 1) begin : g_last
			assign next_byte = '0;
		end else begin : g_mid
			assign next_byte = d_row[j+1];
		end

		fld_drain_cell u_cell (
			.clk       (clk),
			.ctl       (dctl),
			.load_byte (c_row[j+1]),
			.next_byte (next_byte),
			.d_q       (d_row[j])
		);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q  <= LEN_RESET;
			busy_q <= 1'b0;
			rcnt_q <= '0;
			supp_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (cfg_acc) begin
				cfg_q  <= cfg_data;
				busy_q <= 1'b1;
				rcnt_q <= RW'(CELLS);
			end else if (busy_q) begin
				rcnt_q <= rcnt_q - RW'(1);
				if (rcnt_q == RW'(1)) begin
					busy_q <= 1'b0;
				end
			end

			if (in_acc) begin
				if (supp_q != '0) begin
					supp_q <= supp_q - SW'(1);
				end else if (hit) begin
					supp_q <= SW'(len_eff) + SW'(1);
				end
			end

			if (frame_load) begin
				cnt_q <= len_eff;
			end else if (pop) begin
				cnt_q <= cnt_q - LW'(1);
			end
		end
	end

`ifndef ASSERT_OFF
	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> in_stall)
		else $error("byte taken while realigning");

	a_load_into_empty: assert property (@(posedge clk) disable iff (!arst_n)
		frame_load |-> (cnt_q == '0))
		else $error("frame loaded over pending bytes");

	a_suppress_set: assert property (@(posedge clk) disable iff (!arst_n)
		frame_load |=> (supp_q == SW'($past(len_eff)) + SW'(1)))
		else $error("suppress count not armed after frame");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LW'(MAX_PAYLOAD))
		else $error("drain count out of range");

	a_cfg_starts_realign: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_acc |=> (busy_q && (rcnt_q == RW'(CELLS))))
		else $error("config write did not start realign");
`endif

endmodule

// ----- dv/fixed_length_frame_deframer_tb.sv -----
// Testbench for the fixed-length frame deframer: directed and random byte streams checked against a predictor.
`timescale 1ns / 1ps

module fixed_length_frame_deframer_tb;
	import fld_pkg::*;

	localparam int MAX_PAYLOAD = 64;
	localparam int WIN_DEPTH   = MAX_PAYLOAD + 2;
	localparam int SETTLE      = 8;
	localparam int END_QUIET   = MAX_PAYLOAD + 16;
	localparam int LONG_HOLD   = 300;		// output hold-off for the back-pressure test
	localparam int STUCK_LIMIT = 2000;		// cycles with no handshake at all
	localparam int PRINT_CAP   = 40;

	typedef struct {
		byte_t data;
		logic  is_last;
	} payload_beat_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	byte_t            rx_byte;
	logic             out_valid;
	logic             out_stall;
	byte_t            payload_byte;
	logic             frame_last;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data;

	// Predictor state: received history (entry 0 newest), pending skip count, length.
	byte_t            rx_history [WIN_DEPTH] = '{default: 8'h00};
	logic [CFG_W-1:0] skip_left   = '0;
	logic [CFG_W-1:0] len_setting = LEN_RESET;

	payload_beat_t    expected_payload [$];
	int               mismatch_count = 0;
	int               stuck_cycles   = 0;
	bit               pace_on        = 1'b1;
	bit               hold_req       = 1'b0;

	fixed_length_frame_deframer #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.payload_byte(payload_byte),
		.frame_last  (frame_last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------- prediction

	// Length in force: 0 counts as 1, anything above the window counts as the maximum.
	function automatic int frame_len();
		int n;
		n = len_setting;
		if (n < 1)
			n = 1;
		if (n > MAX_PAYLOAD)
			n = MAX_PAYLOAD;
		return n;
	endfunction

	// Shift one byte into the history and queue the payload of any frame it closes.
	task automatic deframe_byte(input byte_t b);
		int n;
		payload_beat_t beat;
		n = frame_len();
		for (int i = WIN_DEPTH - 1; i > 0; i--)
			rx_history[i] = rx_history[i-1];
		rx_history[0] = b;
		if (skip_left != 0) begin
			// just after an accepted frame: the byte is only recorded
			skip_left = skip_left - 1'b1;
		end else if (rx_history[n+1] == START_MARK && rx_history[0] == END_MARK) begin
			for (int k = 0; k < n; k++) begin
				beat.data    = rx_history[n-k];
				beat.is_last = (k == n - 1);
				expected_payload = {expected_payload, beat};
			end
			skip_left = CFG_W'(n + 1);
		end
	endtask

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_CAP)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : check_payload
		payload_beat_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_payload.size() == 0) begin
				report_mismatch($sformatf("unexpected payload byte %02h last %b",
					payload_byte, frame_last));
			end else begin
				want = expected_payload.pop_front();
				if (payload_byte !== want.data)
					report_mismatch($sformatf("payload_byte %02h, want %02h",
						payload_byte, want.data));
				if (frame_last !== want.is_last)
					report_mismatch($sformatf("frame_last %b, want %b on byte %02h",
						frame_last, want.is_last, want.data));
			end
		end
	end

	// Ends the run if no handshake of any kind happens for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ---------------------------------------------------------------- pacing

	// Idle length: mostly none, some short, a few long; none when pacing is off.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!pace_on || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Output side: random stalls, or one long hold-off when a test asks for it.
	initial begin : out_pacing
		int n;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else begin
				n = pick_gap();
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- drivers

	task automatic send_byte(input byte_t b);
		int n;
		n = pick_gap();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall !== 1'b0);
		deframe_byte(b);
	endtask

	// Stop offering items, wait for every expected byte, then let the block settle.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_payload.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_length(input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		len_setting = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic send_frame(input int n);
		send_byte(START_MARK);
		for (int k = 0; k < n; k++)
			send_byte(pick_payload_byte());
		send_byte(END_MARK);
	endtask

	// Payload content with markers mixed in, so false frames show up inside real ones.
	function automatic byte_t pick_payload_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return START_MARK;
		if (r < 25)
			return END_MARK;
		return byte_t'($urandom_range(0, 255));
	endfunction

	// ---------------------------------------------------------------- tests

	// Fresh window holds zeros, so markers alone cannot form a frame yet.
	task automatic test_unfilled_window();
		send_byte(END_MARK);
		send_byte(START_MARK);
		send_byte(END_MARK);
		send_byte(8'hFF);
	endtask

	// Length 0 behaves as 1; then a start marker inside an accepted frame is skipped.
	task automatic test_length_floor();
		wait_drained();
		write_length('0);
		send_byte(START_MARK);
		send_byte(8'hFF);
		send_byte(END_MARK);
		send_byte(START_MARK);
		send_byte(START_MARK);
		send_byte(END_MARK);
		send_byte(END_MARK);	// inner '&' ... '\n' would match but is suppressed
		send_byte(8'h00);
	endtask

	// Payload of extreme bytes and both marker values.
	task automatic test_marker_payload();
		wait_drained();
		write_length(7'd4);
		send_byte(START_MARK);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(START_MARK);
		send_byte(END_MARK);
		send_byte(END_MARK);
	endtask

	// Shorter length while a suppression is still counting: it runs out at its old count.
	task automatic test_length_change();
		wait_drained();
		write_length(7'd3);
		repeat (6)
			send_byte(8'h00);	// let any earlier suppression run out
		send_byte(START_MARK);
		send_byte(8'h11);
		send_byte(8'h22);
		send_byte(8'h33);
		send_byte(END_MARK);
		wait_drained();
		write_length(7'd1);
		send_byte(START_MARK);
		send_byte(8'h55);
		send_byte(END_MARK);
		send_byte(START_MARK);
		send_byte(END_MARK);
		send_byte(START_MARK);
		send_byte(8'h5A);
		send_byte(END_MARK);
	endtask

	// Receiver holds off while frames arrive back to back, so the input has to stall.
	task automatic test_output_backpressure();
		wait_drained();
		write_length(7'd2);
		pace_on  = 1'b0;
		hold_req = 1'b1;
		repeat (8)
			send_frame(2);
		wait_drained();
		pace_on = 1'b1;
	endtask

	task automatic run_stream_phase(input logic [CFG_W-1:0] len_code, input int budget,
		input bit paced);
		int sent;
		int n;
		int r;
		wait_drained();
		write_length(len_code);
		pace_on = paced;
		n = frame_len();
		sent = 0;
		while (sent < budget) begin
			r = $urandom_range(0, 99);
			if (sent == 0 || r < 70) begin
				send_frame(n);
				sent += n + 2;
			end else if (r < 85) begin
				// one byte short or one too many between the markers
				send_frame(r[0] ? n + 1 : n - 1);
				sent += n + 2;
			end else begin
				repeat ($urandom_range(1, 4)) begin
					send_byte(pick_payload_byte());
					sent++;
				end
			end
		end
	endtask

	task automatic test_random_stream();
		run_stream_phase(7'd3,   18, 1'b1);
		run_stream_phase(7'd11,  13, 1'b0);
		run_stream_phase(7'd2,   16, 1'b1);
		run_stream_phase(7'd64,  66, 1'b1);
		run_stream_phase(7'd5,   16, 1'b1);
		run_stream_phase(7'd127, 66, 1'b0);
		run_stream_phase(7'd6,   16, 1'b1);
		pace_on = 1'b1;
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n    = 1'b0;
		in_valid  <= 1'b0;
		rx_byte   <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unfilled_window();
		test_length_floor();
		test_marker_payload();
		test_length_change();
		test_output_backpressure();
		test_random_stream();

		wait_drained();
		repeat (END_QUIET) @(posedge clk);
		if (mismatch_count == 0 && expected_payload.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- fixed_length_frame_deframer.f -----
sv/fld_pkg.sv
sv/fld_win_cell.sv
sv/fld_drain_cell.sv
sv/fixed_length_frame_deframer.sv
dv/fixed_length_frame_deframer_tb.sv
